// ===== hw/rtl/kbt_pkg.sv =====
// Shared sizes, codes and the request token carried along the node cell chain.
package kbt_pkg;

  localparam int CAPACITY   = 128;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int KEY_W      = 8;
  localparam int NODE_IDX_W = 7;

  localparam logic       MODE_INSERT = 1'b0;
  localparam logic       MODE_SEARCH = 1'b1;

  localparam logic [1:0] SIDE_LEFT  = 2'd0;
  localparam logic [1:0] SIDE_RIGHT = 2'd1;
  localparam logic [1:0] SIDE_ROOT  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_NO_PARENT   = 3'd2,
    ST_SIDE_TAKEN  = 3'd3,
    ST_ROOT_EXISTS = 3'd4,
    ST_NOT_FOUND   = 3'd5
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   idx;
    logic               lp;
    logic [KEY_W-1:0]   lk;
    logic               rp;
    logic [KEY_W-1:0]   rk;
  } res_t;

  typedef struct packed {
    logic               valid;
    logic               srch;
    logic               full;
    logic [1:0]         side;
    logic [KEY_W-1:0]   pkey;
    logic [KEY_W-1:0]   nkey;
    logic               found;
    logic               done;
    res_t               res;
  } tok_t;

endpackage

// ===== hw/rtl/kbt_cell.sv =====
// One table entry: key and child links, plus the request stage that passes to the next entry.
module kbt_cell
  import kbt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic [CNT_W-1:0] cnt,
  input  tok_t             tok_i,
  output tok_t             tok_o
);

  logic [KEY_W-1:0] key_r;
  logic             lv_r;
  logic [KEY_W-1:0] lk_r;
  logic             rv_r;
  logic [KEY_W-1:0] rk_r;
  tok_t             tok_r;
  tok_t             tok_nxt;

  logic             occ;
  logic [KEY_W-1:0] match_key;
  logic             hit;
  logic             alloc;
  logic             taken;
  logic             wr_left;
  logic             wr_right;

  assign occ       = CNT_W'(cell_idx) < cnt;
  assign match_key = tok_i.srch ? tok_i.nkey : tok_i.pkey;
  assign hit       = tok_i.valid & ~tok_i.done & ~tok_i.found & occ & (key_r == match_key);
  assign alloc     = tok_i.valid & ~tok_i.done & tok_i.found & ~tok_i.srch & ~occ;
  assign taken     = ((tok_i.side == SIDE_LEFT) & lv_r) | ((tok_i.side == SIDE_RIGHT) & rv_r);
  assign wr_left   = hit & ~tok_i.srch & ~tok_i.full & ~taken & (tok_i.side == SIDE_LEFT);
  assign wr_right  = hit & ~tok_i.srch & ~tok_i.full & ~taken & (tok_i.side == SIDE_RIGHT);

  always_comb begin
    tok_nxt = tok_i;
    if (hit) begin
      tok_nxt.found = 1'b1;
      if (tok_i.srch) begin
        tok_nxt.done       = 1'b1;
        tok_nxt.res.status = ST_OK;
        tok_nxt.res.idx    = cell_idx;
        tok_nxt.res.lp     = lv_r;
        tok_nxt.res.lk     = lv_r ? lk_r : '0;
        tok_nxt.res.rp     = rv_r;
        tok_nxt.res.rk     = rv_r ? rk_r : '0;
      end else if (tok_i.full) begin
        tok_nxt.done       = 1'b1;
        tok_nxt.res.status = ST_FULL;
      end else if (taken) begin
        tok_nxt.done       = 1'b1;
        tok_nxt.res.status = ST_SIDE_TAKEN;
      end
    end else if (alloc) begin
      tok_nxt.done       = 1'b1;
      tok_nxt.res.status = ST_OK;
      tok_nxt.res.idx    = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc) begin
      key_r <= tok_i.nkey;
      lv_r  <= 1'b0;
      rv_r  <= 1'b0;
    end
    if (wr_left) begin
      lv_r <= 1'b1;
      lk_r <= tok_i.nkey;
    end
    if (wr_right) begin
      rv_r <= 1'b1;
      rk_r <= tok_i.nkey;
    end
  end

  assign tok_o = tok_r;

endmodule

// ===== hw/rtl/keyed_binary_tree_node_table_core.sv =====
// Top level of the keyed binary tree node table: request entry, cell chain and result register.
//
// The tree lives in a chain of CAPACITY node cells, one table entry per cell, entries filled in
// order from index 0. Each request walks the chain one cell per cycle: the first cell whose key
// matches acts as the search hit or the insert parent, and the first free cell takes a new node.
// The result of a request passes through the registers of all CAPACITY cells before it is
// registered in the output register. The block works on one request at a time: no new request
// is accepted until the last one has left the chain; in_stall is high from acceptance until the
// request leaves the chain, and while a result waits in the spare holding stage. A finished
// result waits in the output register (with one spare holding stage) while the next request is
// taken. Entries need no clearing after reset: only the node count and control flags are reset.
module keyed_binary_tree_node_table_core
  import kbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_mode,
  input  logic [KEY_W-1:0]      in_parent_key,
  input  logic [KEY_W-1:0]      in_node_key,
  input  logic [1:0]            in_side,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_status,
  output logic [NODE_IDX_W-1:0] out_node_index,
  output logic                  out_left_present,
  output logic [KEY_W-1:0]      out_left_key,
  output logic                  out_right_present,
  output logic [KEY_W-1:0]      out_right_key
);

  tok_t                     chain [CAPACITY+1];
  tok_t                     head;
  logic                     busy_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     out_v_r;
  res_t                     out_r;
  logic                     pend_v_r;
  res_t                     pend_r;
  logic                     accept;
  logic                     out_ready;
  tok_t                     ext;
  res_t                     fin;
  logic [IDX_W+NODE_IDX_W-1:0] idx_ext;

  assign in_stall  = busy_r | pend_v_r;
  assign accept    = in_valid & ~in_stall;
  assign out_ready = ~out_v_r | ~out_stall;

  always_comb begin
    head            = '0;
    head.valid      = accept;
    head.srch       = (in_mode == MODE_SEARCH);
    head.full       = (cnt_r >= CNT_W'(CAPACITY));
    head.side       = in_side;
    head.pkey       = in_parent_key;
    head.nkey       = in_node_key;
    head.res.status = ST_OK;
    if ((in_mode == MODE_INSERT) && (in_side == SIDE_ROOT)) begin
      if (cnt_r == '0) begin
        head.found = 1'b1;
      end else begin
        head.done       = 1'b1;
        head.res.status = ST_ROOT_EXISTS;
      end
    end
  end

  assign chain[0] = head;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kbt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .cnt      (cnt_r),
      .tok_i    (chain[i]),
      .tok_o    (chain[i+1])
    );
  end

  assign ext = chain[CAPACITY];

  always_comb begin
    fin = ext.res;
    if (!ext.done) begin
      fin        = '0;
      fin.status = ext.srch ? ST_NOT_FOUND : ST_NO_PARENT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end
      if (ext.valid) begin
        busy_r <= 1'b0;
        if (!ext.srch && (fin.status == ST_OK)) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        if (out_ready) begin
          out_v_r <= 1'b1;
        end else begin
          pend_v_r <= 1'b1;
        end
      end else if (pend_v_r && out_ready) begin
        out_v_r  <= 1'b1;
        pend_v_r <= 1'b0;
      end else if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ext.valid) begin
      if (out_ready) begin
        out_r <= fin;
      end else begin
        pend_r <= fin;
      end
    end else if (pend_v_r && out_ready) begin
      out_r <= pend_r;
    end
  end

  assign idx_ext           = {{NODE_IDX_W{1'b0}}, out_r.idx};
  assign out_valid         = out_v_r;
  assign out_status        = out_r.status;
  assign out_node_index    = idx_ext[NODE_IDX_W-1:0];
  assign out_left_present  = out_r.lp;
  assign out_left_key      = out_r.lk;
  assign out_right_present = out_r.rp;
  assign out_right_key     = out_r.rk;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the keyed binary tree node table: directed and random requests checked against a tree model.
module tb
  import kbt_pkg::*;
();

  localparam logic [1:0] SIDE_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = CAPACITY + 16;

  typedef struct {
    status_t               status;
    logic [NODE_IDX_W-1:0] index;
    logic                  left_present;
    logic [KEY_W-1:0]      left_key;
    logic                  right_present;
    logic [KEY_W-1:0]      right_key;
  } tree_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_mode = MODE_INSERT;
  logic [KEY_W-1:0]      in_parent_key = '0;
  logic [KEY_W-1:0]      in_node_key = '0;
  logic [1:0]            in_side = SIDE_LEFT;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            out_status;
  logic [NODE_IDX_W-1:0] out_node_index;
  logic                  out_left_present;
  logic [KEY_W-1:0]      out_left_key;
  logic                  out_right_present;
  logic [KEY_W-1:0]      out_right_key;

  logic [KEY_W-1:0] tree_key [CAPACITY];
  int unsigned      tree_left [CAPACITY];
  int unsigned      tree_right [CAPACITY];
  bit               tree_has_left [CAPACITY];
  bit               tree_has_right [CAPACITY];
  int unsigned      tree_count = 0;

  tree_result_t pending_results [$];
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int cycle_count = 0;
  int hold_until = 0;
  int errors = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int status_seen [6];

  keyed_binary_tree_node_table_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_parent_key     (in_parent_key),
    .in_node_key       (in_node_key),
    .in_side           (in_side),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_node_index    (out_node_index),
    .out_left_present  (out_left_present),
    .out_left_key      (out_left_key),
    .out_right_present (out_right_present),
    .out_right_key     (out_right_key)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic int find_key(logic [KEY_W-1:0] key);
    for (int i = 0; i < int'(tree_count); i++) begin
      if (tree_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void store_node(int unsigned at, logic [KEY_W-1:0] key);
    tree_key[at] = key;
    tree_left[at] = 0;
    tree_right[at] = 0;
    tree_has_left[at] = 1'b0;
    tree_has_right[at] = 1'b0;
  endfunction

  function automatic tree_result_t tree_apply(logic mode, logic [KEY_W-1:0] pkey,
                                              logic [KEY_W-1:0] nkey, logic [1:0] side);
    tree_result_t r;
    int hit;
    r.status = ST_OK;
    r.index = '0;
    r.left_present = 1'b0;
    r.left_key = '0;
    r.right_present = 1'b0;
    r.right_key = '0;
    if (mode == MODE_SEARCH) begin
      hit = find_key(nkey);
      if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        r.index = hit[NODE_IDX_W-1:0];
        if (tree_has_left[hit]) begin
          r.left_present = 1'b1;
          r.left_key = tree_key[tree_left[hit]];
        end
        if (tree_has_right[hit]) begin
          r.right_present = 1'b1;
          r.right_key = tree_key[tree_right[hit]];
        end
      end
    end else if (side == SIDE_ROOT) begin
      if (tree_count == 0) begin
        store_node(0, nkey);
        tree_count = 1;
      end else begin
        r.status = ST_ROOT_EXISTS;
      end
    end else begin
      hit = find_key(pkey);
      if (hit < 0) begin
        r.status = ST_NO_PARENT;
      end else if (tree_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else if ((side == SIDE_LEFT && tree_has_left[hit]) ||
                   (side == SIDE_RIGHT && tree_has_right[hit])) begin
        r.status = ST_SIDE_TAKEN;
      end else begin
        store_node(tree_count, nkey);
        if (side == SIDE_LEFT) begin
          tree_left[hit] = tree_count;
          tree_has_left[hit] = 1'b1;
        end else if (side == SIDE_RIGHT) begin
          tree_right[hit] = tree_count;
          tree_has_right[hit] = 1'b1;
        end
        r.index = tree_count[NODE_IDX_W-1:0];
        tree_count++;
      end
    end
    return r;
  endfunction

  task automatic send_request(logic mode, logic [KEY_W-1:0] pkey, logic [KEY_W-1:0] nkey,
                              logic [1:0] side);
    if (in_gap_pct > 0 && $urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_gap_pct);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_parent_key <= pkey;
    in_node_key <= nkey;
    in_side <= side;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(tree_apply(mode, pkey, nkey, side));
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_random_item();
    int pick;
    logic [KEY_W-1:0] any_key;
    logic [KEY_W-1:0] stored_key;
    logic [1:0] side;
    pick = $urandom_range(99);
    any_key = KEY_W'($urandom_range(255));
    stored_key = (tree_count > 0) ? tree_key[$urandom_range(tree_count - 1)] : any_key;
    side = 2'($urandom_range(3));
    if (pick < 40) begin
      if ($urandom_range(99) < 88) begin
        side = 2'($urandom_range(1));
      end else begin
        side = $urandom_range(1) ? SIDE_NONE : SIDE_ROOT;
      end
      send_request(MODE_INSERT, stored_key, KEY_W'($urandom_range(255)), side);
    end else if (pick < 50) begin
      send_request(MODE_INSERT, any_key, KEY_W'($urandom_range(255)), side);
    end else if (pick < 85) begin
      send_request(MODE_SEARCH, any_key, stored_key, side);
    end else begin
      send_request(MODE_SEARCH, stored_key, any_key, side);
    end
  endtask

  task automatic test_empty_table();
    in_gap_pct = 0;
    out_stall_pct = 0;
    send_request(MODE_SEARCH, 8'hFF, 8'h00, SIDE_ROOT);
    send_request(MODE_INSERT, 8'hFF, 8'h01, SIDE_LEFT);
    send_request(MODE_INSERT, 8'h00, 8'hFE, SIDE_NONE);
    wait_drained();
  endtask

  task automatic test_root_and_children();
    send_request(MODE_INSERT, 8'h5A, 8'h80, SIDE_ROOT);
    send_request(MODE_INSERT, 8'h80, 8'h11, SIDE_ROOT);
    send_request(MODE_INSERT, 8'h80, 8'h00, SIDE_LEFT);
    send_request(MODE_INSERT, 8'h80, 8'hFF, SIDE_RIGHT);
    send_request(MODE_INSERT, 8'h80, 8'h21, SIDE_LEFT);
    send_request(MODE_INSERT, 8'h80, 8'h22, SIDE_RIGHT);
    send_request(MODE_INSERT, 8'hFF, 8'h7F, SIDE_NONE);
    send_request(MODE_INSERT, 8'h00, 8'h80, SIDE_LEFT);
    send_request(MODE_SEARCH, 8'h00, 8'h80, SIDE_LEFT);
    send_request(MODE_SEARCH, 8'h80, 8'hFF, SIDE_RIGHT);
    send_request(MODE_SEARCH, 8'hFF, 8'h00, SIDE_NONE);
    send_request(MODE_SEARCH, 8'h80, 8'h42, SIDE_ROOT);
    send_request(MODE_INSERT, 8'h80, 8'h33, SIDE_LEFT);
    send_request(MODE_INSERT, 8'h13, 8'h33, SIDE_RIGHT);
    wait_drained();
  endtask

  task automatic test_random_traffic(int count, int gap_pct, int stall_pct);
    in_gap_pct = gap_pct;
    out_stall_pct = stall_pct;
    repeat (count) send_random_item();
    wait_drained();
  endtask

  task automatic test_fill_table();
    int tries;
    tries = 0;
    in_gap_pct = 0;
    out_stall_pct = 0;
    while (tree_count < CAPACITY && tries < 4 * CAPACITY) begin
      send_request(MODE_INSERT, tree_key[$urandom_range(tree_count - 1)],
                   KEY_W'($urandom_range(255)), 2'($urandom_range(1)));
      tries++;
    end
    wait_drained();
  endtask

  task automatic test_full_table();
    int spare;
    spare = 0;
    while (spare < 255 && find_key(spare[KEY_W-1:0]) >= 0) spare++;
    send_request(MODE_INSERT, tree_key[0], 8'h33, SIDE_LEFT);
    send_request(MODE_INSERT, spare[KEY_W-1:0], 8'h33, SIDE_RIGHT);
    send_request(MODE_INSERT, tree_key[tree_count - 1], 8'h44, SIDE_NONE);
    send_request(MODE_INSERT, 8'h00, 8'h55, SIDE_ROOT);
    send_request(MODE_SEARCH, 8'h00, tree_key[tree_count - 1], SIDE_LEFT);
    wait_drained();
  endtask

  task automatic test_backpressure();
    in_gap_pct = 0;
    out_stall_pct = 0;
    hold_until = cycle_count + 6 * DRAIN_CYCLES;
    repeat (6) send_random_item();
    wait_drained();
  endtask

  always @(posedge clk) begin
    tree_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, status %0d index %0d", $time,
                 out_status, out_node_index);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        status_seen[want.status]++;
        if (out_status !== want.status || out_node_index !== want.index ||
            out_left_present !== want.left_present || out_left_key !== want.left_key ||
            out_right_present !== want.right_present || out_right_key !== want.right_key) begin
          errors++;
          $display("%0t: mismatch, expected st %0d idx %0d l %0b/%h r %0b/%h", $time,
                   want.status, want.index, want.left_present, want.left_key,
                   want.right_present, want.right_key);
          $display("%0t:           actual st %0d idx %0d l %0b/%h r %0b/%h", $time,
                   out_status, out_node_index, out_left_present, out_left_key,
                   out_right_present, out_right_key);
        end
      end
    end
    out_stall <= (cycle_count < hold_until) || ($urandom_range(99) < out_stall_pct);
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_root_and_children();
    test_random_traffic(360, 0, 0);
    test_random_traffic(360, 73, 0);
    test_random_traffic(360, 0, 73);
    test_random_traffic(360, 23, 23);
    test_fill_table();
    test_full_table();
    test_backpressure();
    test_random_traffic(150, 0, 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d requests, %0d results checked, tree at %0d of %0d nodes",
             requests_sent, results_checked, tree_count, CAPACITY);
    $display("statuses: ok %0d full %0d no-parent %0d side-taken %0d root-exists %0d miss %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NO_PARENT],
             status_seen[ST_SIDE_TAKEN], status_seen[ST_ROOT_EXISTS], status_seen[ST_NOT_FOUND]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
